>>> sv/tgdc_pkg.sv
// Package for the trajectory goal-distance cost unit.
// Holds the widths, register indexes, reset values and the shared settings struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tgdc_pkg;

  localparam int unsigned MAX_STEPS_DEF = 1024;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned COST_W        = 48;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y   = 3'd7;

  // Reset values of the registers.
  localparam logic [31:0] THRESHOLD_RST = 32'd91750;
  localparam logic [15:0] WEIGHT_RST    = 16'd1280;
  localparam logic [3:0]  POWER_RST     = 4'd1;

  // Settings seen by the back end.
  typedef struct packed {
    logic                       enable;
    logic [31:0]                threshold;
    logic [15:0]                weight;
    logic [3:0]                 power;
    logic signed [COORD_W-1:0]  goal_x;
    logic signed [COORD_W-1:0]  goal_y;
    logic signed [COORD_W-1:0]  robot_x;
    logic signed [COORD_W-1:0]  robot_y;
  } cfg_t;

endpackage
`default_nettype wire

>>> sv/tgdc_if.sv
// Channel interfaces for the goal-distance cost unit: point input and cost result.
// Depends on tgdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tgdc_in_if;
  import tgdc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;
  logic [COST_W-1:0]         prior_cost;
  modport source(output valid, point_x, point_y, last_point, prior_cost, input ready);
  modport sink(input valid, point_x, point_y, last_point, prior_cost, output ready);
endinterface

interface tgdc_out_if;
  import tgdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] total_cost;
  logic              saturated;
  modport source(output valid, total_cost, saturated, input ready);
  modport sink(input valid, total_cost, saturated, output ready);
endinterface
`default_nettype wire

>>> sv/tgdc_front.sv
// Front end: accepts trajectory points, takes the distance to the goal with a
// bit-per-cycle square root and sums it. Pushes one entry per trajectory. Uses tgdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tgdc_front #(
  parameter int unsigned MAX_STEPS = tgdc_pkg::MAX_STEPS_DEF,
  parameter int unsigned CNT_W     = $clog2(MAX_STEPS + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tgdc_in_if.sink                                in_ch,
  input  wire logic signed [tgdc_pkg::COORD_W-1:0] goal_x,
  input  wire logic signed [tgdc_pkg::COORD_W-1:0] goal_y,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output logic [tgdc_pkg::COST_W-1:0]            q_sum,
  output logic [CNT_W-1:0]                       q_count,
  output logic [tgdc_pkg::COST_W-1:0]            q_prior
);
  import tgdc_pkg::*;

  localparam int unsigned ROOT_W = COORD_W + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam logic [CNT_W-1:0] STEP_LIMIT = CNT_W'(MAX_STEPS);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_DIFF = 6'b000010,
    F_SQ   = 6'b000100,
    F_SUM  = 6'b001000,
    F_ROOT = 6'b010000,
    F_END  = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [COORD_W-1:0] px_r, py_r;
  logic                      last_r, do_acc_r;
  logic [COST_W-1:0]         prior_r;
  logic [ROOT_W-1:0]         adx_r, ady_r;
  logic [RAD_W-1:0]          sqx_r, sqy_r, rad_r;
  logic [ROOT_W-1:0]         root_r, mask_r;
  logic [COST_W-1:0]         sum_r;
  logic [CNT_W-1:0]          count_r;

  logic signed [ROOT_W-1:0]  dx, dy;
  logic [ROOT_W-1:0]         cand;
  logic [RAD_W-1:0]          cand_sq;
  logic [COST_W:0]           sum_ext;
  logic                      accept;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == F_IDLE) && !q_full;

  // Differences to the goal, widened by one bit so they cannot wrap.
  assign dx = ROOT_W'(px_r) - ROOT_W'(goal_x);
  assign dy = ROOT_W'(py_r) - ROOT_W'(goal_y);

  // Trial root bit and its square.
  assign cand    = root_r | mask_r;
  assign cand_sq = RAD_W'(cand) * RAD_W'(cand);

  assign sum_ext = {1'b0, sum_r} + (COST_W + 1)'(root_r);

  // Queue entry.
  assign q_push  = (state_r == F_END) && last_r;
  assign q_sum   = (do_acc_r && sum_ext[COST_W]) ? COST_MAX :
                   (do_acc_r ? sum_ext[COST_W-1:0] : sum_r);
  assign q_count = do_acc_r ? count_r + CNT_W'(1) : count_r;
  assign q_prior = prior_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = (count_r < STEP_LIMIT) ? F_DIFF : F_END;
      end
      F_DIFF: state_nxt = F_SQ;
      F_SQ:   state_nxt = F_SUM;
      F_SUM:  state_nxt = F_ROOT;
      F_ROOT: begin
        if (mask_r[0]) state_nxt = F_END;
      end
      F_END:  state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_END) begin
        if (last_r) begin
          sum_r   <= '0;
          count_r <= '0;
        end else begin
          sum_r   <= q_sum;
          count_r <= q_count;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          px_r     <= in_ch.point_x;
          py_r     <= in_ch.point_y;
          last_r   <= in_ch.last_point;
          prior_r  <= in_ch.prior_cost;
          do_acc_r <= count_r < STEP_LIMIT;
        end
      end
      F_DIFF: begin
        adx_r <= dx[ROOT_W-1] ? ROOT_W'(-dx) : ROOT_W'(dx);
        ady_r <= dy[ROOT_W-1] ? ROOT_W'(-dy) : ROOT_W'(dy);
      end
      F_SQ: begin
        sqx_r <= RAD_W'(adx_r) * RAD_W'(adx_r);
        sqy_r <= RAD_W'(ady_r) * RAD_W'(ady_r);
      end
      F_SUM: begin
        rad_r  <= sqx_r + sqy_r;
        root_r <= '0;
        mask_r <= {1'b1, {(ROOT_W-1){1'b0}}};
      end
      F_ROOT: begin
        if (cand_sq <= rad_r) root_r <= cand;
        mask_r <= mask_r >> 1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/tgdc_queue.sv
// Short queue between the front and back ends, one entry per trajectory.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module tgdc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rp_r];

  // Pointer wrap.
  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop)  rp_r <= bump(rp_r);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> sv/tgdc_back.sv
// Back end: gates on robot range, divides the distance sum by the count, weights
// the mean, raises it to the power with a serial multiplier and adds the prior. Uses tgdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tgdc_back #(
  parameter int unsigned CNT_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tgdc_pkg::cfg_t                cfg,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic [tgdc_pkg::COST_W-1:0]   q_sum,
  input  wire logic [CNT_W-1:0]              q_count,
  input  wire logic [tgdc_pkg::COST_W-1:0]   q_prior,
  tgdc_out_if.source                         out_ch
);
  import tgdc_pkg::*;

  localparam int unsigned OP_W   = 56;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned DCNT_W = $clog2(COST_W + 1);
  localparam logic [COST_W-1:0] ONE_Q16 = COST_W'(65536);

  typedef enum logic [10:0] {
    B_IDLE   = 11'b00000000001,
    B_RDIFF  = 11'b00000000010,
    B_GATE   = 11'b00000000100,
    B_CHECK  = 11'b00000001000,
    B_DIV    = 11'b00000010000,
    B_WMUL   = 11'b00000100000,
    B_PSTART = 11'b00001000000,
    B_PMUL   = 11'b00010000000,
    B_PCHK   = 11'b00100000000,
    B_FIN    = 11'b01000000000,
    B_OUT    = 11'b10000000000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [COST_W-1:0]  sum_r, prior_r, quot_r, acc_r, cost_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W:0]     rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [DIFF_W-1:0]  rdx_r, rdy_r;
  logic [SQ_W-1:0]    rsx_r, rsy_r;
  logic [63:0]        th_sq_r;
  logic [OP_W-1:0]    v_r, b_r;
  logic [PROD_W-1:0]  a_r, prod_r;
  logic [3:0]         k_r;
  logic               sat_r;
  logic [COST_W-1:0]  total_r;
  logic               total_sat_r;

  logic signed [DIFF_W-1:0] rdx, rdy;
  logic [CNT_W+1:0]         rem_sh;
  logic                     rem_ge;
  logic                     near;
  logic [COST_W:0]          total_ext;

  assign rdx = DIFF_W'(cfg.robot_x) - DIFF_W'(cfg.goal_x);
  assign rdy = DIFF_W'(cfg.robot_y) - DIFF_W'(cfg.goal_y);

  assign near = ({1'b0, rsx_r} + {1'b0, rsy_r}) < (SQ_W + 1)'(th_sq_r);

  // One restoring divide step.
  assign rem_sh = {rem_r, sum_r[COST_W-1]};
  assign rem_ge = rem_sh >= (CNT_W + 2)'(count_r);

  assign total_ext = {1'b0, prior_r} + {1'b0, cost_r};

  assign q_pop             = (state_r == B_IDLE) && !q_empty;
  assign out_ch.valid      = state_r == B_OUT;
  assign out_ch.total_cost = total_r;
  assign out_ch.saturated  = total_sat_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = B_RDIFF;
      end
      B_RDIFF: state_nxt = B_GATE;
      B_GATE:  state_nxt = B_CHECK;
      B_CHECK: begin
        state_nxt = (cfg.enable && near && count_r != '0) ? B_DIV : B_FIN;
      end
      B_DIV: begin
        if (dcnt_r == DCNT_W'(COST_W - 1)) state_nxt = B_WMUL;
      end
      B_WMUL: begin
        if (b_r == '0) state_nxt = B_PSTART;
      end
      B_PSTART: state_nxt = (k_r == cfg.power) ? B_FIN : B_PMUL;
      B_PMUL: begin
        if (b_r == '0) state_nxt = B_PCHK;
      end
      B_PCHK: state_nxt = (prod_r[PROD_W-1:64] != '0) ? B_FIN : B_PSTART;
      B_FIN:  state_nxt = B_OUT;
      B_OUT: begin
        if (out_ch.ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        sum_r   <= q_sum;
        count_r <= q_count;
        prior_r <= q_prior;
        cost_r  <= '0;
        sat_r   <= 1'b0;
      end
      B_RDIFF: begin
        rdx_r <= rdx[DIFF_W-1] ? DIFF_W'(-rdx) : DIFF_W'(rdx);
        rdy_r <= rdy[DIFF_W-1] ? DIFF_W'(-rdy) : DIFF_W'(rdy);
      end
      B_GATE: begin
        rsx_r   <= SQ_W'(rdx_r) * SQ_W'(rdx_r);
        rsy_r   <= SQ_W'(rdy_r) * SQ_W'(rdy_r);
        th_sq_r <= 64'(cfg.threshold) * 64'(cfg.threshold);
      end
      B_CHECK: begin
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      B_DIV: begin
        rem_r  <= rem_ge ? (CNT_W + 1)'(rem_sh - (CNT_W + 2)'(count_r))
                         : rem_sh[CNT_W:0];
        quot_r <= {quot_r[COST_W-2:0], rem_ge};
        sum_r  <= sum_r << 1;
        dcnt_r <= dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(COST_W - 1)) begin
          // Load the weighting multiply with the finished quotient.
          a_r    <= PROD_W'({quot_r[COST_W-2:0], rem_ge});
          b_r    <= OP_W'(cfg.weight);
          prod_r <= '0;
        end
      end
      B_WMUL, B_PMUL: begin
        if (b_r != '0) begin
          if (b_r[0]) prod_r <= prod_r + a_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end else if (state_r == B_WMUL) begin
          v_r   <= prod_r[OP_W+7:8];
          acc_r <= ONE_Q16;
          k_r   <= '0;
        end
      end
      B_PSTART: begin
        if (k_r == cfg.power) cost_r <= acc_r;
        a_r    <= PROD_W'(acc_r);
        b_r    <= v_r;
        prod_r <= '0;
      end
      B_PCHK: begin
        if (prod_r[PROD_W-1:64] != '0) begin
          sat_r  <= 1'b1;
          cost_r <= COST_MAX;
        end else begin
          acc_r <= prod_r[63:16];
          k_r   <= k_r + 4'd1;
        end
      end
      B_FIN: begin
        total_r     <= total_ext[COST_W] ? COST_MAX : total_ext[COST_W-1:0];
        total_sat_r <= sat_r || total_ext[COST_W];
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/trajectory_goal_distance_cost_unit.sv
// Top level of the trajectory goal-distance cost unit: configuration registers,
// front end, queue and back end. Depends on tgdc_pkg and tgdc_if.
//
// Points are Q16.16 metres; one point is taken at a time and occupies the front
// end through its difference, square, sum and root steps, the square root
// resolving one root bit per cycle over 33 bits. A trajectory's last point hands
// its distance sum, count and prior cost through a two-entry queue to the back
// end, which pops the queue, runs the range gate and, if it passes, the
// restoring divide, the weight multiply and each power step in a bit-serial
// multiplier, closing the power loop, then forms the total and makes the
// output transfer. The front end keeps taking points while the back end works
// and the queue has room.
`timescale 1ns / 1ps
`default_nettype none
module trajectory_goal_distance_cost_unit #(
  parameter int unsigned MAX_STEPS = tgdc_pkg::MAX_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tgdc_in_if.sink                                in_ch,
  tgdc_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [tgdc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [tgdc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tgdc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned Q_W   = 2 * COST_W + CNT_W;

  cfg_t cfg_r;

  logic              q_push, q_pop, q_full, q_empty;
  logic [COST_W-1:0] f_sum, f_prior;
  logic [CNT_W-1:0]  f_count;
  logic [Q_W-1:0]    q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b1;
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.weight    <= WEIGHT_RST;
      cfg_r.power     <= POWER_RST;
      cfg_r.goal_x    <= '0;
      cfg_r.goal_y    <= '0;
      cfg_r.robot_x   <= '0;
      cfg_r.robot_y   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLE:    cfg_r.enable    <= cfg_wdata[0];
        REG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        REG_WEIGHT:    cfg_r.weight    <= cfg_wdata[15:0];
        REG_POWER:     cfg_r.power     <= cfg_wdata[3:0];
        REG_GOAL_X:    cfg_r.goal_x    <= cfg_wdata;
        REG_GOAL_Y:    cfg_r.goal_y    <= cfg_wdata;
        REG_ROBOT_X:   cfg_r.robot_x   <= cfg_wdata;
        REG_ROBOT_Y:   cfg_r.robot_y   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tgdc_front #(
    .MAX_STEPS(MAX_STEPS),
    .CNT_W    (CNT_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .goal_x (cfg_r.goal_x),
    .goal_y (cfg_r.goal_y),
    .q_full (q_full),
    .q_push (q_push),
    .q_sum  (f_sum),
    .q_count(f_count),
    .q_prior(f_prior)
  );

  tgdc_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_sum, f_count, f_prior}),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  tgdc_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .q_sum  (q_out[Q_W-1 -: COST_W]),
    .q_count(q_out[COST_W +: CNT_W]),
    .q_prior(q_out[COST_W-1:0]),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> tb/tb_trajectory_goal_distance_cost_unit.sv
// Testbench for trajectory_goal_distance_cost_unit: drives trajectory points under
// random gaps and stalls and checks every cost transfer against a built-in predictor.
// Depends on tgdc_pkg, tgdc_if and the unit itself.
`timescale 1ns / 1ps
module tb_trajectory_goal_distance_cost_unit;
  import tgdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int MAX_PTS        = MAX_STEPS_DEF;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               last;
    logic [47:0]        prior;
  } point_t;

  typedef struct {
    logic [47:0] total;
    logic        sat;
  } cost_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tgdc_in_if  in_ch();
  tgdc_out_if out_ch();

  trajectory_goal_distance_cost_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: register copy, running distance sum and point count.
  cfg_t        shadow_cfg;
  logic [47:0] dist_total;
  logic [10:0] pts_seen;

  point_t point_q[$];
  cost_t  cost_due[$];

  bit in_fire, out_fire, hold_points;
  int in_gap, out_stall, gap_max, stall_max;
  int mismatches, n_points, n_traj, n_sat, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact squared distance between two Q16.16 positions.
  function automatic logic [65:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] bx, logic signed [31:0] by);
    logic signed [33:0] dx, dy;
    logic [65:0] mx, my;
    dx = 34'(ax) - 34'(bx);
    dy = 34'(ay) - 34'(by);
    mx = dx < 0 ? 66'(-dx) : 66'(dx);
    my = dy < 0 ? 66'(-dy) : 66'(dy);
    return mx * mx + my * my;
  endfunction

  function automatic logic [32:0] root_floor(logic [65:0] v);
    logic [32:0] r, t;
    logic [65:0] sq;
    r = '0;
    for (int i = 32; i >= 0; i--) begin
      t = r | (33'd1 << i);
      sq = 66'(t);
      sq = sq * sq;
      if (sq <= v) r = t;
    end
    return r;
  endfunction

  // Folds one accepted point into the running sum; on a last point queues its cost.
  task automatic account_point(point_t p);
    logic [49:0]  sum;
    logic [65:0]  robot_sq;
    logic [63:0]  thr_sq, mean, v, acc;
    logic [127:0] prod;
    logic [48:0]  total;
    logic [47:0]  cost;
    logic         sat;
    cost_t        c;
    if (pts_seen < MAX_PTS) begin
      sum = 50'(dist_total) + 50'(root_floor(dist_sq(p.px, p.py, shadow_cfg.goal_x,
                                                      shadow_cfg.goal_y)));
      dist_total = sum > 50'(COST_MAX) ? COST_MAX : sum[47:0];
      pts_seen = pts_seen + 11'd1;
    end
    n_points++;
    if (!p.last) return;
    sat = 1'b0;
    cost = '0;
    robot_sq = dist_sq(shadow_cfg.robot_x, shadow_cfg.robot_y,
                       shadow_cfg.goal_x, shadow_cfg.goal_y);
    thr_sq = 64'(shadow_cfg.threshold) * 64'(shadow_cfg.threshold);
    if (shadow_cfg.enable && robot_sq < 66'(thr_sq) && pts_seen != 0) begin
      mean = 64'(dist_total) / 64'(pts_seen);
      v = (mean * 64'(shadow_cfg.weight)) >> 8;
      acc = 64'd65536;
      for (int k = 0; k < shadow_cfg.power && !sat; k++) begin
        prod = 128'(acc) * 128'(v);
        if (prod[127:64] != 0) sat = 1'b1;
        else begin
          acc = prod[63:0] >> 16;
          if (acc > 64'(COST_MAX)) sat = 1'b1;
        end
      end
      cost = sat ? COST_MAX : acc[47:0];
    end
    total = 49'(p.prior) + 49'(cost);
    if (total > 49'(COST_MAX)) begin
      total = 49'(COST_MAX);
      sat = 1'b1;
    end
    c.total = total[47:0];
    c.sat = sat;
    cost_due.push_back(c);
    n_traj++;
    if (sat) n_sat++;
    dist_total = '0;
    pts_seen = '0;
  endtask

  // Sample both handshakes, update the predictor and check each result.
  always @(posedge clk) begin
    cost_t c;
    point_t p;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (in_fire) begin
      p.px = in_ch.point_x;
      p.py = in_ch.point_y;
      p.last = in_ch.last_point;
      p.prior = in_ch.prior_cost;
      account_point(p);
    end
    if (out_fire) begin
      if (cost_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cost transfer: total=%h sat=%b",
                   out_ch.total_cost, out_ch.saturated);
      end else begin
        c = cost_due.pop_front();
        if (out_ch.total_cost !== c.total || out_ch.saturated !== c.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cost mismatch: expected total=%h sat=%b, got total=%h sat=%b",
                     c.total, c.sat, out_ch.total_cost, out_ch.saturated);
        end
      end
    end
    // Watchdog over cycles with work outstanding but no transfer.
    if (in_fire || out_fire || (point_q.size() == 0 && cost_due.size() == 0 && !in_ch.valid))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", cost_due.size());
      $display("tb_trajectory_goal_distance_cost_unit NOT OK");
      $finish;
    end
  end

  // Point driver: one gap drawn per point.
  always @(negedge clk) begin
    point_t p;
    if (!rst_n) in_ch.valid <= 1'b0;
    else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!hold_points && point_q.size() != 0) begin
        p = point_q.pop_front();
        in_ch.point_x <= p.px;
        in_ch.point_y <= p.py;
        in_ch.last_point <= p.last;
        in_ch.prior_cost <= p.prior;
        in_ch.valid <= 1'b1;
        in_gap = $urandom_range(0, gap_max);
      end else in_ch.valid <= 1'b0;
    end
  end

  // Result sink: one stall drawn per result.
  always @(negedge clk) begin
    if (out_fire) out_stall = $urandom_range(0, stall_max);
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ENABLE:    shadow_cfg.enable = data[0];
      REG_THRESHOLD: shadow_cfg.threshold = data;
      REG_WEIGHT:    shadow_cfg.weight = data[15:0];
      REG_POWER:     shadow_cfg.power = data[3:0];
      REG_GOAL_X:    shadow_cfg.goal_x = data;
      REG_GOAL_Y:    shadow_cfg.goal_y = data;
      REG_ROBOT_X:   shadow_cfg.robot_x = data;
      default:       shadow_cfg.robot_y = data;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic last, logic [47:0] prior);
    point_t p;
    p.px = x;
    p.py = y;
    p.last = last;
    p.prior = prior;
    point_q.push_back(p);
  endtask

  // Waits until every queued point is taken and every cost has arrived.
  task automatic drain();
    while (point_q.size() != 0 || in_ch.valid || cost_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_prior();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 48'($urandom_range(0, 32'hFFFF_FFFF));
      2: return COST_MAX - 48'($urandom_range(0, 1 << 24));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  // One random trajectory; most points lie near the goal, some anywhere.
  task automatic add_traj(int len, bit wide);
    logic [31:0] x, y;
    for (int i = 0; i < len; i++) begin
      if (wide || $urandom_range(0, 7) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = shadow_cfg.goal_x + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        y = shadow_cfg.goal_y + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      end
      add_point(x, y, i == len - 1, rand_prior());
    end
  endtask

  task automatic random_config();
    logic [31:0] gx, gy;
    gx = $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    gy = $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    set_reg(REG_ENABLE, $urandom_range(0, 7) != 0);
    set_reg(REG_THRESHOLD, $urandom_range(0, 5) == 0 ? $urandom
                                                     : $urandom_range(1 << 15, 1 << 22));
    set_reg(REG_WEIGHT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hFFFF)
                                                  : $urandom_range(0, 1024));
    set_reg(REG_POWER, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 3));
    set_reg(REG_GOAL_X, gx);
    set_reg(REG_GOAL_Y, gy);
    set_reg(REG_ROBOT_X, gx + $signed($urandom_range(0, 1 << 20)) - (1 << 19));
    set_reg(REG_ROBOT_Y, gy + $signed($urandom_range(0, 1 << 20)) - (1 << 19));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.last_point = 1'b0;
    in_ch.prior_cost = '0;
    out_ch.ready = 1'b0;
    hold_points = 1'b0;
    gap_max = 19;
    stall_max = 19;
    shadow_cfg = '{enable: 1'b1, threshold: THRESHOLD_RST, weight: WEIGHT_RST,
                   power: POWER_RST, default: '0};
    dist_total = '0;
    pts_seen = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: reset settings, zero and unit distance, coordinate extremes.
    add_point(32'd0, 32'd0, 1'b1, 48'd0);
    add_point(32'd65536, 32'd0, 1'b1, 48'd100);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 48'd7);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 48'd7);
    add_point(32'h8000_0000, 32'h8000_0000, 1'b1, 48'd5);
    add_point(32'd0, 32'd0, 1'b1, COST_MAX);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, COST_MAX);
    drain();
    // Disabled: prior passes through.
    set_reg(REG_ENABLE, 32'd0);
    add_point(32'h0010_0000, 32'h0, 1'b0, 48'd0);
    add_point(32'h0020_0000, 32'h0, 1'b1, 48'h1234_5678_9ABC);
    drain();
    // Robot outside the threshold, then threshold at its extremes.
    set_reg(REG_ENABLE, 32'd1);
    set_reg(REG_ROBOT_X, 32'h0002_0000);
    add_point(32'h0001_0000, 32'h0, 1'b1, 48'd9);
    drain();
    set_reg(REG_THRESHOLD, 32'd0);
    set_reg(REG_ROBOT_X, 32'd0);
    add_point(32'h0001_0000, 32'h0, 1'b1, 48'd9);
    drain();
    set_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    set_reg(REG_ROBOT_X, 32'h8000_0000);
    set_reg(REG_ROBOT_Y, 32'h8000_0000);
    set_reg(REG_GOAL_X, 32'h7FFF_FFFF);
    set_reg(REG_GOAL_Y, 32'h7FFF_FFFF);
    add_point(32'h7FFF_0000, 32'h7FFF_0000, 1'b1, 48'd1);
    drain();
    // Power zero, power fifteen with full weight, and zero weight.
    set_reg(REG_ROBOT_X, 32'h7FFF_FFFF);
    set_reg(REG_ROBOT_Y, 32'h7FFF_FFFF);
    set_reg(REG_POWER, 32'd0);
    add_point(32'h0, 32'h0, 1'b1, 48'd3);
    drain();
    set_reg(REG_POWER, 32'd15);
    set_reg(REG_WEIGHT, 32'hFFFF);
    add_point(32'h7FF0_0000, 32'h7FFF_0000, 1'b1, 48'd3);
    add_point(32'h7FFF_8000, 32'h7FFF_FFFF, 1'b1, 48'd3);
    drain();
    set_reg(REG_WEIGHT, 32'd0);
    set_reg(REG_POWER, 32'd8);
    add_point(32'h0, 32'h0, 1'b1, 48'd11);
    drain();

    // Random phases, some without gaps or stalls, one with a paused sender.
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      gap_max = (ph % 4 == 1) ? 0 : 19;
      stall_max = (ph % 4 == 2) ? 0 : 19;
      for (int t = 0; t < 13; t++)
        add_traj($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 4),
                 $urandom_range(0, 5) == 0);
      if (ph == 3) begin
        while (point_q.size() > 60) @(posedge clk);
        hold_points = 1'b1;
        while (in_ch.valid || cost_due.size() != 0) @(posedge clk);
        hold_points = 1'b0;
      end
      drain();
    end

    // A trajectory longer than the step limit.
    gap_max = 2;
    set_reg(REG_ENABLE, 32'd1);
    set_reg(REG_POWER, 32'd1);
    set_reg(REG_WEIGHT, 32'd256);
    set_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    for (int i = 0; i < MAX_PTS + 4; i++)
      add_point(shadow_cfg.goal_x + (i < MAX_PTS ? 32'h0001_0000 : 32'h0100_0000),
                shadow_cfg.goal_y, i == MAX_PTS + 3, 48'd17);
    drain();

    $display("Covered %0d points in %0d trajectories, %0d results saturated.",
             n_points, n_traj, n_sat);
    $display("%0d mismatches.", mismatches);
    if (mismatches == 0) $display("tb_trajectory_goal_distance_cost_unit OK");
    else $display("tb_trajectory_goal_distance_cost_unit NOT OK");
    $finish;
  end

endmodule
